// ===== design/mlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlcd_pkg: shared types and constants for the monochrome LCD drawing engine
// Holds the command codes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package mlcd_pkg;

    // Command codes carried in the opcode field.
    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_CLR    = 3'd1,
        OP_LINE   = 3'd2,
        OP_CIRCLE = 3'd3,
        OP_CLS    = 3'd4,
        OP_CLROW  = 3'd5,
        OP_SCROLL = 3'd6,
        OP_READ   = 3'd7
    } t_opcode;

    // Configuration register indexes.
    localparam logic [0:0] REG_SCROLL_TOP = 1'd0;
    localparam logic [0:0] REG_SCROLL_END = 1'd1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,    // clearing pass after reset
        ST_IDLE,
        ST_PIX_RD,   // issue read of one pixel column
        ST_PIX_WR,   // modify and write back
        ST_LINE,     // line step decision
        ST_CIRC,     // circle: compute next octant point
        ST_COL_RD,   // column sweep read
        ST_COL_WR,   // column sweep write
        ST_READ,     // read column result
        ST_DONE      // result held on the output
    } t_state;

endpackage

// ===== design/monochrome_lcd_drawing_engine.sv =====
// ----------------------------------------------------------------------------
// monochrome_lcd_drawing_engine
// Drawing command engine over a one-bit LCD frame store held in a column RAM.
// ----------------------------------------------------------------------------
// The frame store is one synchronous RAM of SCREEN_WIDTH words, one word per
// pixel column, accessed through a single address port. After reset a
// clearing pass writes every column before the first command is taken.
// Each plotted pixel is a read, then a modified write-back; set and clear
// plot one pixel, a line adds a step state between pixels, and a circle
// passes its decision state before each plotted point, eight points per
// step of the octant loop. Clear screen, clear row and scroll sweep every
// column once, reading then writing back each column. A read column reads
// the addressed column into the result. One command is in work at a time;
// a result is held in an output register until taken, and the next command
// is not accepted until then.
module monochrome_lcd_drawing_engine #(
    parameter int SCREEN_WIDTH  = 120,
    parameter int SCREEN_HEIGHT = 32,
    parameter int CELL_HEIGHT   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command stream: opcode[2:0], start_x[10:3], start_y[18:11],
    // end_x[26:19], end_y[34:27], radius[42:35], zero fill up to 48 bits.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    // Result stream: column_bits[31:0], done_opcode[34:32], zero fill to 40.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data
);
    import mlcd_pkg::*;

    localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int YW = $clog2(SCREEN_HEIGHT);
    localparam int CW = 12; // signed coordinate width for drawing math

    // Frame store.
    logic [SCREEN_HEIGHT-1:0] r_mem [SCREEN_WIDTH];
    logic [SCREEN_HEIGHT-1:0] r_rdata;
    logic                     mem_we;
    logic [XW-1:0]            mem_addr;
    logic [SCREEN_HEIGHT-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    // Registers.
    t_state r_state, n_state;
    logic [2:0] r_top, r_end;
    logic [2:0] r_op;
    logic [7:0] r_arg_sx;
    logic       r_pix_on;
    logic signed [CW-1:0] r_px, r_py;          // pixel being plotted
    logic signed [CW-1:0] r_x, r_y, r_x1, r_y1;
    logic signed [CW-1:0] r_dx, r_dy, r_err;
    logic signed [CW-1:0] r_cx, r_cy, r_a, r_b, r_d;
    logic [2:0] r_oct;
    logic       r_last;                        // last pixel of the command
    logic [XW-1:0] r_col;
    logic [31:0]   r_res_bits;
    logic          r_out_valid;
    logic [SCREEN_HEIGHT-1:0] r_keep;          // clear mask for sweeps
    logic          r_scroll;
    logic [YW:0]   r_lo, r_hi;

    // Input field unpack.
    logic [2:0] in_op;
    logic [7:0] in_sx, in_sy, in_ex, in_ey, in_r;
    assign in_op = s_axis_tdata[2:0];
    assign in_sx = s_axis_tdata[10:3];
    assign in_sy = s_axis_tdata[18:11];
    assign in_ex = s_axis_tdata[26:19];
    assign in_ey = s_axis_tdata[34:27];
    assign in_r  = s_axis_tdata[42:35];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_op, r_res_bits};

    // Pixel bounds check.
    logic px_in;
    assign px_in = (r_px >= 0) && (r_px < CW'(SCREEN_WIDTH)) &&
                   (r_py >= 0) && (r_py < CW'(SCREEN_HEIGHT));

    // Octant point of the circle for the current octant index.
    logic signed [CW-1:0] oct_x, oct_y;
    always_comb begin
        unique case (r_oct)
            3'd0: begin oct_x = r_cx + r_a; oct_y = r_cy + r_b; end
            3'd1: begin oct_x = r_cx - r_a; oct_y = r_cy + r_b; end
            3'd2: begin oct_x = r_cx + r_a; oct_y = r_cy - r_b; end
            3'd3: begin oct_x = r_cx - r_a; oct_y = r_cy - r_b; end
            3'd4: begin oct_x = r_cx + r_b; oct_y = r_cy + r_a; end
            3'd5: begin oct_x = r_cx - r_b; oct_y = r_cy + r_a; end
            3'd6: begin oct_x = r_cx + r_b; oct_y = r_cy - r_a; end
            default: begin oct_x = r_cx - r_b; oct_y = r_cy - r_a; end
        endcase
    end

    // Line step.
    logic signed [CW-1:0] twice;
    logic signed [CW-1:0] line_nx, line_ny;
    assign twice   = r_err <<< 1;
    assign line_nx = (twice > -r_dy) ?
                     ((r_x1 > r_x) ? r_x + CW'(1) : r_x - CW'(1)) : r_x;
    assign line_ny = (twice < r_dx) ?
                     ((r_y1 > r_y) ? r_y + CW'(1) : r_y - CW'(1)) : r_y;

    // Scroll: per-column shifted word. Rows lo..hi-CELL-1 take row+CELL,
    // rows hi-CELL..hi-1 clear, others keep.
    logic [SCREEN_HEIGHT-1:0] scroll_word, shifted;
    assign shifted = r_rdata >> CELL_HEIGHT;
    always_comb begin
        for (int j = 0; j < SCREEN_HEIGHT; j++) begin
            if (j >= int'(r_lo) && j + CELL_HEIGHT < int'(r_hi))
                scroll_word[j] = shifted[j];
            else if (j < int'(r_hi) && j + CELL_HEIGHT >= int'(r_hi))
                scroll_word[j] = 1'b0;
            else
                scroll_word[j] = r_rdata[j];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_col == XW'(SCREEN_WIDTH - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (t_opcode'(in_op))
                        OP_SET, OP_CLR, OP_LINE: n_state = ST_PIX_RD;
                        OP_CIRCLE: n_state = ST_CIRC;
                        OP_CLS, OP_CLROW, OP_SCROLL: n_state = ST_COL_RD;
                        default: n_state = ST_READ;
                    endcase
                end
            end
            ST_PIX_RD: n_state = ST_PIX_WR;
            ST_PIX_WR: begin
                if (r_last)                         n_state = ST_DONE;
                else if (t_opcode'(r_op) == OP_LINE) n_state = ST_LINE;
                else                                n_state = ST_CIRC;
            end
            ST_LINE:   n_state = ST_PIX_RD;
            ST_CIRC:   n_state = (r_a > r_b) ? ST_DONE : ST_PIX_RD;
            ST_COL_RD: n_state = ST_COL_WR;
            ST_COL_WR: n_state = (r_col == XW'(SCREEN_WIDTH - 1)) ? ST_DONE : ST_COL_RD;
            ST_READ:   n_state = ST_DONE;
            ST_DONE:   if (m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_col;
        mem_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                mem_addr = ({1'b0, in_sx} < 9'(SCREEN_WIDTH)) ? XW'(in_sx) : '0;
            end
            ST_PIX_RD: begin
                mem_addr = px_in ? XW'(r_px) : '0;
            end
            ST_PIX_WR: begin
                mem_addr  = px_in ? XW'(r_px) : '0;
                mem_we    = px_in;
                mem_wdata = r_rdata;
                if (px_in) mem_wdata[YW'(r_py)] = r_pix_on;
            end
            ST_COL_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_scroll ? scroll_word : (r_rdata & r_keep);
            end
            default: ;
        endcase
    end

    // Datapath and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_top       <= 3'd0;
            r_end       <= 3'd4;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_SCROLL_TOP) r_top <= i_cfg_data;
                else                               r_end <= i_cfg_data;
            end
            unique case (r_state)
                ST_CLEAR: r_col <= r_col + 1'b1;
                ST_IDLE: if (s_axis_tvalid) begin
                    r_op       <= in_op;
                    r_arg_sx   <= in_sx;
                    r_col      <= '0;
                    r_res_bits <= '0;
                    r_pix_on   <= (t_opcode'(in_op) != OP_CLR);
                    r_px       <= CW'(in_sx);
                    r_py       <= CW'(in_sy);
                    r_x        <= CW'(in_sx);
                    r_y        <= CW'(in_sy);
                    r_x1       <= CW'(in_ex);
                    r_y1       <= CW'(in_ey);
                    r_dx <= (in_ex > in_sx) ? CW'(in_ex - in_sx) : CW'(in_sx - in_ex);
                    r_dy <= (in_ey > in_sy) ? CW'(in_ey - in_sy) : CW'(in_sy - in_ey);
                    r_err <= ((in_ex > in_sx) ? CW'(in_ex - in_sx) : CW'(in_sx - in_ex))
                           - ((in_ey > in_sy) ? CW'(in_ey - in_sy) : CW'(in_sy - in_ey));
                    // Set and clear plot one pixel; a circle ends on its own test.
                    r_last <= (t_opcode'(in_op) == OP_SET) ||
                              (t_opcode'(in_op) == OP_CLR) ||
                              ((t_opcode'(in_op) == OP_LINE) &&
                               in_sx == in_ex && in_sy == in_ey);
                    r_cx  <= CW'(in_sx);
                    r_cy  <= CW'(in_sy);
                    r_a   <= '0;
                    r_b   <= CW'(in_r);
                    r_d   <= CW'(3) - (CW'(in_r) <<< 1);
                    r_oct <= 3'd0;
                    r_scroll <= (t_opcode'(in_op) == OP_SCROLL);
                    // Scroll window, falling back to the whole screen.
                    if ((r_end * CELL_HEIGHT) <= (r_top * CELL_HEIGHT) ||
                        (r_end * CELL_HEIGHT) > SCREEN_HEIGHT) begin
                        r_lo <= '0;
                        r_hi <= (YW+1)'(SCREEN_HEIGHT);
                    end else begin
                        r_lo <= (YW+1)'(r_top * CELL_HEIGHT);
                        r_hi <= (YW+1)'(r_end * CELL_HEIGHT);
                    end
                    // Clear mask for clear screen or a text row.
                    for (int j = 0; j < SCREEN_HEIGHT; j++) begin
                        if (t_opcode'(in_op) == OP_CLS)
                            r_keep[j] <= 1'b0;
                        else
                            r_keep[j] <= !(j >= int'(in_sy) * CELL_HEIGHT &&
                                           j <  int'(in_sy) * CELL_HEIGHT + CELL_HEIGHT);
                    end
                end
                ST_LINE: begin
                    r_x  <= line_nx;
                    r_y  <= line_ny;
                    r_px <= line_nx;
                    r_py <= line_ny;
                    if (twice > -r_dy && twice < r_dx) begin
                        r_err <= r_err - r_dy + r_dx;
                    end else if (twice > -r_dy) begin
                        r_err <= r_err - r_dy;
                    end else if (twice < r_dx) begin
                        r_err <= r_err + r_dx;
                    end
                    r_last <= (line_nx == r_x1) && (line_ny == r_y1);
                end
                ST_CIRC: begin
                    r_px <= oct_x;
                    r_py <= oct_y;
                end
                ST_PIX_WR: begin
                    if (t_opcode'(r_op) == OP_CIRCLE) begin
                        r_oct <= r_oct + 1'b1;
                        if (r_oct == 3'd7) begin
                            if (r_d < 0) begin
                                r_d <= r_d + (r_a <<< 2) + CW'(6);
                            end else begin
                                r_d <= r_d + ((r_a - r_b) <<< 2) + CW'(10);
                                r_b <= r_b - CW'(1);
                            end
                            r_a <= r_a + CW'(1);
                        end
                    end
                    if (r_last) r_out_valid <= 1'b1;
                end
                ST_COL_WR: begin
                    r_col <= r_col + 1'b1;
                    if (r_col == XW'(SCREEN_WIDTH - 1)) r_out_valid <= 1'b1;
                end
                ST_READ: begin
                    if ({1'b0, r_arg_sx} < 9'(SCREEN_WIDTH))
                        r_res_bits <= 32'(r_rdata);
                    r_out_valid <= 1'b1;
                end
                ST_DONE: if (m_axis_tready) r_out_valid <= 1'b0;
                default: ;
            endcase
            // Circle ends when a exceeds b at the decision point.
            if (r_state == ST_CIRC && r_a > r_b) r_out_valid <= 1'b1;
        end
    end

endmodule
